// ===== design/blag_pkg.sv =====
`default_nettype none

package blag_pkg;

  // Field and register widths fixed by the interface.
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DIM_W  = 2;
  localparam int SAMPLE_W   = 16;
  localparam int ADDR_W     = 48;

  // Largest length a 13-bit register can express.
  localparam int LEN_MAX    = (2 ** CFG_W) - 1;

  // The block volume is fed to the 13-bit multiplier port in 12-bit slices.
  localparam int CHUNK_W    = 12;
  localparam int CHUNKS     = ADDR_W / CHUNK_W;

  // Restoring division of a 14-bit dividend takes one step per bit.
  localparam int DIV_W      = CFG_W + 1;
  localparam int DIV_STEPS  = DIV_W;
  localparam int STEP_W     = 4;

  typedef enum logic [2:0] {
    MOP_NONE = 3'd0,
    MOP_VOL  = 3'd1,
    MOP_OFF  = 3'd2,
    MOP_BID  = 3'd3,
    MOP_ADDR = 3'd4
  } mul_op_t;

  typedef struct packed {
    mul_op_t              mop;
    logic                 first;
    logic [CFG_DIM_W-1:0] dim;
    logic [1:0]           chunk;
    logic                 div_init;
    logic                 div_step;
    logic                 bpd_wr;
    logic                 ready;
    logic                 load_out;
  } agu_cmd_t;

  typedef struct packed {
    logic in_take;
    logic cfg_wr;
    logic out_free;
  } agu_sts_t;

endpackage

`default_nettype wire

// ===== design/blag_dp.sv =====
`default_nettype none

module blag_dp import blag_pkg::*; #(
  parameter int NUM_DIMS   = 4,
  parameter int MAX_POINTS = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [SAMPLE_W-1:0]  in_sample_code,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ADDR_W-1:0]         out_word_address,
  output logic [SAMPLE_W-1:0]       out_sample_out,
  output logic                      out_last_point,
  input  wire agu_cmd_t             cmd,
  output agu_sts_t                  sts
);

  localparam int LIM   = (MAX_POINTS > LEN_MAX) ? LEN_MAX : MAX_POINTS;
  localparam int IDX_W = $clog2(LIM);
  localparam int DIM_W = (NUM_DIMS > 2) ? 2 : 1;
  localparam int CMP_W = CFG_W + 1;
  localparam logic [CFG_W-1:0] LIM_LEN = CFG_W'(LIM);

  function automatic logic [CFG_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > LIM_LEN) begin
      r = LIM_LEN;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [CFG_W-1:0]    size_r    [NUM_DIMS];
  logic [CFG_W-1:0]    blk_r     [NUM_DIMS];
  logic [CFG_W-1:0]    bpd_r     [NUM_DIMS];
  logic [CFG_W-1:0]    eff_size  [NUM_DIMS];
  logic [CFG_W-1:0]    eff_blk   [NUM_DIMS];
  logic [IDX_W-1:0]    pi_r      [NUM_DIMS];
  logic [IDX_W-1:0]    bi_r      [NUM_DIMS];
  logic [IDX_W-1:0]    ibo_r     [NUM_DIMS];
  logic [IDX_W-1:0]    pi_nxt    [NUM_DIMS];
  logic [IDX_W-1:0]    bi_nxt    [NUM_DIMS];
  logic [IDX_W-1:0]    ibo_nxt   [NUM_DIMS];

  logic [ADDR_W-1:0]   vol_r;
  logic [ADDR_W-1:0]   acc_r;
  logic [ADDR_W-1:0]   off_r;
  logic [ADDR_W-1:0]   bid_r;
  logic [DIV_W-1:0]    div_n_r;
  logic [DIV_W-1:0]    div_rem_r;
  logic [DIV_W-1:0]    div_q_r;
  logic [DIV_W-1:0]    div_sh;
  logic [SAMPLE_W-1:0] sample_r;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic                out_last_r;

  logic [ADDR_W-1:0]   mul_a;
  logic [CFG_W-1:0]    mul_b;
  logic [ADDR_W-1:0]   mul_c;
  logic [ADDR_W-1:0]   mul_res;

  logic [DIM_W-1:0]    dsel;
  logic [DIM_W-1:0]    cfg_dsel;
  logic                cfg_dim_ok;
  logic                in_take;
  logic                out_free;
  logic                last;

  assign dsel       = cmd.dim[DIM_W-1:0];
  assign cfg_dsel   = cfg_index[DIM_W-1:0];
  assign cfg_dim_ok = (32'(cfg_index[CFG_DIM_W-1:0]) < NUM_DIMS);

  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      eff_size[d] = clamp_len(size_r[d]);
      eff_blk[d]  = clamp_len(blk_r[d]);
    end
  end

  assign in_take  = in_valid && cmd.ready && !cfg_we;
  assign in_stall = !cmd.ready || cfg_we;
  assign out_free = !out_valid_r || !out_stall;

  assign sts.in_take  = in_take;
  assign sts.cfg_wr   = cfg_we;
  assign sts.out_free = out_free;

  // Shared multiply-accumulate: one 48 x 13 product plus a 48-bit addend.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_c = '0;
    case (cmd.mop)
      MOP_VOL: begin
        mul_a = cmd.first ? ADDR_W'(1) : vol_r;
        mul_b = eff_blk[dsel];
      end
      MOP_OFF: begin
        mul_a = cmd.first ? '0 : acc_r;
        mul_b = eff_blk[dsel];
        mul_c = ADDR_W'(ibo_r[dsel]);
      end
      MOP_BID: begin
        mul_a = cmd.first ? '0 : acc_r;
        mul_b = bpd_r[dsel];
        mul_c = ADDR_W'(bi_r[dsel]);
      end
      MOP_ADDR: begin
        mul_a = cmd.first ? acc_r : bid_r;
        mul_b = CFG_W'(vol_r[cmd.chunk*CHUNK_W +: CHUNK_W]);
        mul_c = cmd.first ? '0 : (acc_r << CHUNK_W);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_res = mul_a * ADDR_W'(mul_b) + mul_c;

  assign div_sh = {div_rem_r[DIV_W-2:0], div_n_r[DIV_W-1]};

  // Odometer advance, first dimension fastest.
  always_comb begin
    logic             carry;
    logic [IDX_W:0]   pi_inc;
    logic [IDX_W:0]   ibo_inc;
    carry = 1'b1;
    for (int d = 0; d < NUM_DIMS; d++) begin
      pi_nxt[d]  = pi_r[d];
      bi_nxt[d]  = bi_r[d];
      ibo_nxt[d] = ibo_r[d];
      pi_inc     = {1'b0, pi_r[d]} + (IDX_W+1)'(1);
      ibo_inc    = {1'b0, ibo_r[d]} + (IDX_W+1)'(1);
      if (carry) begin
        if (CMP_W'(ibo_inc) >= CMP_W'(eff_blk[d])) begin
          ibo_nxt[d] = '0;
          bi_nxt[d]  = bi_r[d] + IDX_W'(1);
        end else begin
          ibo_nxt[d] = ibo_inc[IDX_W-1:0];
        end
        if (CMP_W'(pi_inc) < CMP_W'(eff_size[d])) begin
          pi_nxt[d] = pi_inc[IDX_W-1:0];
          carry     = 1'b0;
        end else begin
          pi_nxt[d]  = '0;
          bi_nxt[d]  = '0;
          ibo_nxt[d] = '0;
        end
      end
    end
  end

  always_comb begin
    last = 1'b1;
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (CMP_W'(pi_r[d]) + CMP_W'(1) != CMP_W'(eff_size[d])) begin
        last = 1'b0;
      end
    end
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        size_r[d] <= CFG_W'(1);
        blk_r[d]  <= CFG_W'(1);
        pi_r[d]   <= '0;
        bi_r[d]   <= '0;
        ibo_r[d]  <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_dim_ok) begin
          if (cfg_index[CFG_IDX_W-1]) begin
            blk_r[cfg_dsel] <= cfg_data;
          end else begin
            size_r[cfg_dsel] <= cfg_data;
          end
        end
        for (int d = 0; d < NUM_DIMS; d++) begin
          pi_r[d]  <= '0;
          bi_r[d]  <= '0;
          ibo_r[d] <= '0;
        end
      end else if (cmd.load_out) begin
        for (int d = 0; d < NUM_DIMS; d++) begin
          pi_r[d]  <= pi_nxt[d];
          bi_r[d]  <= bi_nxt[d];
          ibo_r[d] <= ibo_nxt[d];
        end
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_n_r   <= DIV_W'(eff_size[dsel]) + DIV_W'(eff_blk[dsel]) - DIV_W'(1);
      div_rem_r <= '0;
      div_q_r   <= '0;
    end else if (cmd.div_step) begin
      div_n_r <= div_n_r << 1;
      if (div_sh >= DIV_W'(eff_blk[dsel])) begin
        div_rem_r <= div_sh - DIV_W'(eff_blk[dsel]);
        div_q_r   <= {div_q_r[DIV_W-2:0], 1'b1};
      end else begin
        div_rem_r <= div_sh;
        div_q_r   <= {div_q_r[DIV_W-2:0], 1'b0};
      end
    end
    if (cmd.bpd_wr) begin
      bpd_r[dsel] <= div_q_r[CFG_W-1:0];
    end
    if (cmd.mop == MOP_VOL) begin
      vol_r <= mul_res;
    end else if (cmd.mop != MOP_NONE) begin
      acc_r <= mul_res;
    end
    if (cmd.mop == MOP_BID && cmd.first) begin
      off_r <= acc_r;
    end
    if (cmd.mop == MOP_ADDR && cmd.first) begin
      bid_r <= acc_r;
    end
    if (in_take) begin
      sample_r <= in_sample_code;
    end
    if (cmd.load_out) begin
      out_addr_r   <= off_r + acc_r;
      out_sample_r <= sample_r;
      out_last_r   <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_word_address = out_addr_r;
  assign out_sample_out   = out_sample_r;
  assign out_last_point   = out_last_r;

endmodule

`default_nettype wire

// ===== design/blag_ctrl.sv =====
`default_nettype none

module blag_ctrl import blag_pkg::*; #(
  parameter int NUM_DIMS = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire agu_sts_t sts,
  output agu_cmd_t      cmd
);

  localparam logic [CFG_DIM_W-1:0] DIM_TOP = CFG_DIM_W'(NUM_DIMS - 1);

  typedef enum logic [8:0] {
    S_DIV_INIT = 9'b000000001,
    S_DIV_RUN  = 9'b000000010,
    S_DIV_WB   = 9'b000000100,
    S_VOL      = 9'b000001000,
    S_IDLE     = 9'b000010000,
    S_OFF      = 9'b000100000,
    S_BID      = 9'b001000000,
    S_ADDR     = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  state_t               state_r;
  state_t               state_nxt;
  logic [CFG_DIM_W-1:0] dim_r;
  logic [CFG_DIM_W-1:0] dim_nxt;
  logic [STEP_W-1:0]    step_r;
  logic [STEP_W-1:0]    step_nxt;

  always_comb begin
    state_nxt = state_r;
    dim_nxt   = dim_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.mop   = MOP_NONE;
    cmd.dim   = dim_r;
    cmd.chunk = step_r[1:0];
    case (state_r)
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DIV_WB;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_DIV_WB: begin
        cmd.bpd_wr = 1'b1;
        if (dim_r == DIM_TOP) begin
          dim_nxt   = '0;
          state_nxt = S_VOL;
        end else begin
          dim_nxt   = dim_r + CFG_DIM_W'(1);
          state_nxt = S_DIV_INIT;
        end
      end
      S_VOL: begin
        cmd.mop   = MOP_VOL;
        cmd.first = (dim_r == '0);
        if (dim_r == DIM_TOP) begin
          state_nxt = S_IDLE;
        end else begin
          dim_nxt = dim_r + CFG_DIM_W'(1);
        end
      end
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (sts.in_take) begin
          dim_nxt   = DIM_TOP;
          state_nxt = S_OFF;
        end
      end
      S_OFF: begin
        cmd.mop   = MOP_OFF;
        cmd.first = (dim_r == DIM_TOP);
        if (dim_r == '0) begin
          dim_nxt   = DIM_TOP;
          state_nxt = S_BID;
        end else begin
          dim_nxt = dim_r - CFG_DIM_W'(1);
        end
      end
      S_BID: begin
        cmd.mop   = MOP_BID;
        cmd.first = (dim_r == DIM_TOP);
        if (dim_r == '0) begin
          step_nxt  = STEP_W'(CHUNKS - 1);
          state_nxt = S_ADDR;
        end else begin
          dim_nxt = dim_r - CFG_DIM_W'(1);
        end
      end
      S_ADDR: begin
        cmd.mop   = MOP_ADDR;
        cmd.first = (step_r == STEP_W'(CHUNKS - 1));
        if (step_r == '0) begin
          state_nxt = S_FINISH;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        dim_nxt   = '0;
        state_nxt = S_DIV_INIT;
      end
    endcase
    // A register write always restarts the derivation pass.
    if (sts.cfg_wr) begin
      dim_nxt   = '0;
      state_nxt = S_DIV_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_DIV_INIT;
      dim_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      dim_r   <= dim_nxt;
      step_r  <= step_nxt;
    end
  end

  ap_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded while the output register is still held");

  ap_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    sts.cfg_wr |=> state_r == S_DIV_INIT && dim_r == '0)
    else $error("register write did not restart the derivation pass");

  ap_take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sts.in_take |-> state_r == S_IDLE)
    else $error("beat taken outside the idle state");

  ap_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
    sts.in_take |=> state_r == S_OFF && dim_r == DIM_TOP)
    else $error("accepted beat did not start the offset pass");

endmodule

`default_nettype wire

// ===== design/blocked_layout_address_generator_top.sv =====
// A beat is accepted only in the idle state, so the next beat is not taken until the result
// of the last one is loaded into the output register; the single shared 48 x 13
// multiply-accumulate unit walks the offset, block number and address passes.
// Reset: synchronous, active low; registers return to 1 and all counters to zero.
// After reset and after every register write, a derivation pass runs one division
// per dimension and the volume product; in_stall is high.
`default_nettype none

module blocked_layout_address_generator_top import blag_pkg::*; #(
  parameter int MAX_POINTS = 4096,
  parameter int NUM_DIMS   = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [SAMPLE_W-1:0]  in_sample_code,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ADDR_W-1:0]         out_word_address,
  output logic [SAMPLE_W-1:0]       out_sample_out,
  output logic                      out_last_point
);

  // The block is split into a sequencer and a datapath. The sequencer steps
  // through the derivation pass (blocks per dimension by restoring division,
  // then the block volume as a running product) and, for every beat, through
  // three multiply-accumulate passes: the in-block offset and the block
  // number, each evaluated dimension by dimension from the slowest one, and
  // then the block number times the block volume, taken twelve bits of the
  // volume at a time. The final add of the offset is done as the result is
  // written to the output register.
  //
  // The output register decouples the two sides: a new beat is taken while
  // a finished result still waits, and only the final load waits for room.
  // The point, block and in-block counters advance as each result is loaded,
  // first dimension fastest, and wrap to zero after the last point.

  agu_cmd_t cmd;
  agu_sts_t sts;

  blag_ctrl #(
    .NUM_DIMS (NUM_DIMS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  blag_dp #(
    .NUM_DIMS   (NUM_DIMS),
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_code   (in_sample_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word_address (out_word_address),
    .out_sample_out   (out_sample_out),
    .out_last_point   (out_last_point),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

`default_nettype wire
